/* rtl/cbfa_pkg.sv */
// Shared types and constants of the contiguous block fit allocator.
// No dependencies.
package cbfa_pkg;

	localparam int NUM_BLOCKS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_BITS   = $clog2(NUM_BLOCKS);
	localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

	// Fixed field widths
	localparam int FIELD_IDX_W  = 4;
	localparam int FIELD_SIZE_W = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 5;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

	// Placement policies
	localparam logic [1:0] FIT_BEST  = 2'd0;
	localparam logic [1:0] FIT_FIRST = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;
	localparam logic [1:0] FIT_NONE  = 2'd3;

	// Actions
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_ALLOC = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_LOADED    = 2'd0;
	localparam logic [1:0] ST_ALLOCATED = 2'd1;
	localparam logic [1:0] ST_NOFIT     = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic accept;    // latch the input transaction, do a load write
		logic scan_step; // evaluate one table entry
		logic commit;    // load the output register, set the mark
	} cbfa_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic alloc_req; // latched transaction is an allocate
		logic scan_done; // scan index reached the active count
	} cbfa_stat_t;

endpackage

/* rtl/cbfa_dp.sv */
// Datapath of the block fit allocator: config registers, size table, marks,
// scan registers and the output register. Depends on cbfa_pkg.
module cbfa_dp
	import cbfa_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    action,
	input  logic [FIELD_IDX_W-1:0]  block_index,
	input  logic [FIELD_SIZE_W-1:0] size,
	input  cbfa_cmd_t               cmd,
	output cbfa_stat_t              stat,
	output logic [1:0]              status,
	output logic [FIELD_IDX_W-1:0]  assigned_block,
	output logic [FIELD_SIZE_W-1:0] leftover
);

	logic [1:0]           fit_mode_q;
	logic [CNT_BITS-1:0]  block_count_q;
	logic [SIZE_BITS-1:0] sizes_q [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] marks_q;
	logic                 action_q;
	logic [SIZE_BITS-1:0] req_q;
	logic [CNT_BITS-1:0]  idx_q;
	logic                 found_q;
	logic [IDX_BITS-1:0]  pick_q;
	logic [SIZE_BITS-1:0] best_q;
	logic [1:0]           status_q;
	logic [FIELD_IDX_W-1:0]  assigned_q;
	logic [FIELD_SIZE_W-1:0] leftover_q;

	logic [CNT_BITS-1:0]  limit;
	logic [IDX_BITS-1:0]  scan_idx;
	logic [SIZE_BITS-1:0] entry;
	logic [SIZE_BITS-1:0] left;
	logic                 fits;
	logic                 better;
	logic [IDX_BITS-1:0]  load_idx;

	assign limit    = (block_count_q > CNT_BITS'(NUM_BLOCKS)) ? CNT_BITS'(NUM_BLOCKS)
	                                                          : block_count_q;
	assign scan_idx = idx_q[IDX_BITS-1:0];
	assign entry    = sizes_q[scan_idx];
	assign left     = entry - req_q;
	assign fits     = !marks_q[scan_idx] && (entry >= req_q) && (fit_mode_q != FIT_NONE);
	assign better   = !found_q
	               || (fit_mode_q == FIT_BEST  && left < best_q)
	               || (fit_mode_q == FIT_WORST && left > best_q);
	assign load_idx = IDX_BITS'(block_index);

	assign stat.alloc_req = (action_q == ACT_ALLOC);
	assign stat.scan_done = (idx_q >= limit);

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= FIT_BEST;
			block_count_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FIT_MODE) begin
				fit_mode_q <= cfg_data[1:0];
			end else if (cfg_index == CFG_BLOCK_COUNT) begin
				block_count_q <= CNT_BITS'(cfg_data);
			end
		end
	end

	// Size table, no reset
	always_ff @(posedge clk) begin
		if (cmd.accept && action == ACT_LOAD) begin
			sizes_q[load_idx] <= size[SIZE_BITS-1:0];
		end
	end

	// Marks and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				if (action == ACT_LOAD) begin
					marks_q[load_idx] <= 1'b0;
				end
			end else if (cmd.scan_step && !stat.scan_done) begin
				idx_q <= idx_q + CNT_BITS'(1);
				if (fits && better) begin
					found_q <= 1'b1;
				end
			end else if (cmd.commit && action_q == ACT_ALLOC && found_q) begin
				marks_q[pick_q] <= 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q <= action;
			req_q    <= size[SIZE_BITS-1:0];
		end
		if (cmd.scan_step && !stat.scan_done && fits && better) begin
			pick_q <= scan_idx;
			best_q <= left;
		end
		if (cmd.commit) begin
			if (action_q == ACT_LOAD) begin
				status_q   <= ST_LOADED;
				assigned_q <= '0;
				leftover_q <= '0;
			end else if (found_q) begin
				status_q   <= ST_ALLOCATED;
				assigned_q <= FIELD_IDX_W'(pick_q);
				leftover_q <= FIELD_SIZE_W'(best_q);
			end else begin
				status_q   <= ST_NOFIT;
				assigned_q <= '0;
				leftover_q <= '0;
			end
		end
	end

	assign status         = status_q;
	assign assigned_block = assigned_q;
	assign leftover       = leftover_q;

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= CNT_BITS'(NUM_BLOCKS))
		else $error("scan index past table");
	a_pick_behind: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> ({1'b0, pick_q} < idx_q))
		else $error("pick not behind scan index");
	a_mark_set: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && action_q == ACT_ALLOC && found_q) |=> marks_q[$past(pick_q)])
		else $error("chosen block not marked");
`endif

endmodule

/* rtl/cbfa_ctrl.sv */
// Controller of the block fit allocator: accept / scan / finish sequencing
// and the output valid flag. Depends on cbfa_pkg.
module cbfa_ctrl
	import cbfa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  cbfa_stat_t stat,
	output cbfa_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	assign cmd.accept    = in_valid && in_ready;
	assign cmd.scan_step = (state_q == S_SCAN) && !stat.scan_done;
	assign cmd.commit    = (state_q == S_FINISH) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.accept) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// loads leave at once; allocates stay until the scan is done
				if (!stat.alloc_req || stat.scan_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result overwritten");
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("result lost");
	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && stat.scan_done) |=> (state_q == S_FINISH))
		else $error("scan did not finish");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !in_ready)
		else $error("accepted while busy");
`endif

endmodule

/* rtl/contiguous_block_fit_allocator.sv */
// Contiguous block fit allocator, top level (first / best / worst fit).
// Load: accept, then through the scan state to finish, where the result is
// registered once the output is free. Allocate: the scan walks N entries,
// N = min(block_count, 16), one table entry examined per cycle.
// A new transaction is accepted only once the controller is back in idle. Reset
// (arst_n low) clears marks, config and control; block sizes stay undefined until loaded.
module contiguous_block_fit_allocator
	import cbfa_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// config write port
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// input channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    action,
	input  logic [FIELD_IDX_W-1:0]  block_index,
	input  logic [FIELD_SIZE_W-1:0] size,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              status,
	output logic [FIELD_IDX_W-1:0]  assigned_block,
	output logic [FIELD_SIZE_W-1:0] leftover
);

	// Controller sequences accept -> scan -> finish; the datapath holds the
	// table, the running best candidate and the output register. A result
	// waits in the output register while the controller already sits idle.
	cbfa_cmd_t  cmd;
	cbfa_stat_t stat;

	cbfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Load writes the table in the accept cycle; allocate walks entries
	// 0..N-1, keeping the first / smallest / largest leftover by fit_mode.
	cbfa_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.action         (action),
		.block_index    (block_index),
		.size           (size),
		.cmd            (cmd),
		.stat           (stat),
		.status         (status),
		.assigned_block (assigned_block),
		.leftover       (leftover)
	);

endmodule
